// ===== rtl/pac_polar_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// PAC polar encoder assertion macros
// Shared concurrent assertion forms for the encoder core.
// ----------------------------------------------------------------------------
`ifndef PAC_POLAR_ENCODER_CORE_MACROS_SVH
`define PAC_POLAR_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pac encoder assertion failed");

// Next-cycle implication, disabled during reset
`define PAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pac encoder assertion failed");

`endif

// ===== rtl/pacenc_pkg.sv =====
// ----------------------------------------------------------------------------
// PAC encoder package
// Widths, default sizes and configuration register indexes.
// ----------------------------------------------------------------------------
package pacenc_pkg;

    // Port widths fixed by the frame format
    localparam int WORD_W     = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    // Default code size
    localparam int CODE_LEN_DEF = 64;
    localparam int CONV_MEM_DEF = 12;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FROZEN_MASK = 1'b0,
        CFG_CONV_TAPS   = 1'b1
    } cfg_reg_t;

endpackage

// ===== rtl/pacenc_placer.sv =====
// ----------------------------------------------------------------------------
// PAC encoder bit placer
// Holds a rank table (free positions below each position) rebuilt by a
// one-position-per-cycle sweep after reset and after every frozen mask write,
// and scatters information bits into the free positions.
// ----------------------------------------------------------------------------
module pacenc_placer #(
    parameter int CODE_LEN = pacenc_pkg::CODE_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sweep_start,
    input  logic [CODE_LEN-1:0] frozen_mask,
    input  logic [CODE_LEN-1:0] info_bits,
    output logic                sweep_busy,
    output logic [CODE_LEN-1:0] placed_bits
);

    localparam int RANK_W = $clog2(CODE_LEN);

    logic [CODE_LEN-1:0] free_bits;
    logic                busy_reg, busy_next;
    logic [RANK_W-1:0]   pos_reg, pos_next;
    logic [RANK_W-1:0]   count_reg, count_next;
    logic [RANK_W-1:0]   rank_reg [CODE_LEN];

    assign free_bits  = ~frozen_mask;
    assign sweep_busy = busy_reg;

    // Sweep control: walk positions, keep running count of free ones
    always_comb
    begin
        busy_next  = busy_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        if (sweep_start)
        begin
            busy_next  = 1'b1;
            pos_next   = '0;
            count_next = '0;
        end
        else if (busy_reg)
        begin
            pos_next   = pos_reg + RANK_W'(1);
            count_next = count_reg + RANK_W'(free_bits[pos_reg]);
            if (pos_reg == RANK_W'(CODE_LEN - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

    // Rank table, one entry written per sweep cycle
    always_ff @(posedge clk)
    begin
        if (busy_reg && !sweep_start)
        begin
            rank_reg[pos_reg] <= count_reg;
        end
    end

    // Scatter: free position i takes information bit rank(i)
    always_comb
    begin
        for (int i = 0; i < CODE_LEN; i++)
        begin
            placed_bits[i] = free_bits[i] & info_bits[rank_reg[i]];
        end
    end

endmodule

// ===== rtl/pacenc_precoder.sv =====
// ----------------------------------------------------------------------------
// PAC encoder convolutional precoder
// Rate-1 precoder: each bit XORs in the earlier bits selected by the taps,
// with the shift register empty at the start of the frame.
// ----------------------------------------------------------------------------
module pacenc_precoder #(
    parameter int CODE_LEN = pacenc_pkg::CODE_LEN_DEF,
    parameter int CONV_MEM = pacenc_pkg::CONV_MEM_DEF
) (
    input  logic [CONV_MEM-1:0] conv_taps,
    input  logic [CODE_LEN-1:0] in_bits,
    output logic [CODE_LEN-1:0] out_bits
);

    always_comb
    begin
        for (int i = 0; i < CODE_LEN; i++)
        begin
            out_bits[i] = in_bits[i];
            for (int d = 1; d <= CONV_MEM; d++)
            begin
                // taps reaching before the frame start see zeros
                if (d <= i)
                begin
                    out_bits[i] = out_bits[i] ^ (conv_taps[d-1] & in_bits[i-d]);
                end
            end
        end
    end

endmodule

// ===== rtl/pacenc_butterfly.sv =====
// ----------------------------------------------------------------------------
// PAC encoder polar transform
// Natural-order butterfly network, log2 stages of XOR; a butterfly whose
// partner lies past the frame end is skipped.
// ----------------------------------------------------------------------------
module pacenc_butterfly #(
    parameter int CODE_LEN = pacenc_pkg::CODE_LEN_DEF
) (
    input  logic [CODE_LEN-1:0] in_bits,
    output logic [CODE_LEN-1:0] out_bits
);

    localparam int NSTAGE = $clog2(CODE_LEN);

    logic [CODE_LEN-1:0] stage_x [NSTAGE+1];

    assign stage_x[0] = in_bits;

    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_stage
        localparam int K = 1 << s;
        for (genvar p = 0; p < CODE_LEN; p++)
        begin : g_pos
            if (((p & K) == 0) && (p + K < CODE_LEN))
            begin : g_xor
                assign stage_x[s+1][p] = stage_x[s][p] ^ stage_x[s][p+K];
            end
            else
            begin : g_pass
                assign stage_x[s+1][p] = stage_x[s][p];
            end
        end
    end

    assign out_bits = stage_x[NSTAGE];

endmodule

// ===== rtl/pac_polar_encoder_core.sv =====
// ----------------------------------------------------------------------------
// PAC polar encoder core
// One frame per transfer: bit placement, convolutional precoding and polar
// transform between an input register and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries info_word; output channel
//   out_valid/out_ready carries codeword. Bits of codeword at CODE_LEN
//   and above are zero.
//   The encode pass runs from the input register to the result register;
//   one frame is taken every cycle while out_ready is high and no rebuild
//   runs, set by the single register-to-register encode pass.
//   When the receiver stalls, a finished codeword waits in the result
//   register and the input register takes at most one more frame;
//   in_ready drops once both registers are full.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at
//   once. The user must make them only while no frame is in flight;
//   the block does not enforce this. After reset or a frozen_mask write,
//   the rank table is rebuilt with in_ready low; config regs reset to 0.
// ----------------------------------------------------------------------------
`include "pac_polar_encoder_core_macros.svh"

module pac_polar_encoder_core #(
    parameter int CODE_LEN = pacenc_pkg::CODE_LEN_DEF,
    parameter int CONV_MEM = pacenc_pkg::CONV_MEM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pacenc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pacenc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pacenc_pkg::WORD_W-1:0]      info_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pacenc_pkg::WORD_W-1:0]      codeword
);

    logic [CODE_LEN-1:0] frozen_mask_reg, frozen_mask_next;
    logic [CONV_MEM-1:0] conv_taps_reg, conv_taps_next;
    logic                mask_write;
    logic                sweep_busy;

    logic                s1_valid_reg, s1_valid_next;
    logic [CODE_LEN-1:0] info_reg, info_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_LEN-1:0] codeword_reg, codeword_next;
    logic                s1_advance;

    logic [CODE_LEN-1:0] placed_bits;
    logic [CODE_LEN-1:0] precoded_bits;
    logic [CODE_LEN-1:0] encoded_bits;

    // Configuration register writes
    always_comb
    begin
        frozen_mask_next = frozen_mask_reg;
        conv_taps_next   = conv_taps_reg;
        mask_write       = 1'b0;
        if (cfg_wr_en)
        begin
            case (pacenc_pkg::cfg_reg_t'(cfg_index))
                pacenc_pkg::CFG_FROZEN_MASK:
                begin
                    frozen_mask_next = cfg_wdata[CODE_LEN-1:0];
                    mask_write       = 1'b1;
                end
                pacenc_pkg::CFG_CONV_TAPS:
                begin
                    conv_taps_next = cfg_wdata[CONV_MEM-1:0];
                end
                default:
                begin
                    frozen_mask_next = frozen_mask_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frozen_mask_reg <= '0;
            conv_taps_reg   <= '0;
        end
        else
        begin
            frozen_mask_reg <= frozen_mask_next;
            conv_taps_reg   <= conv_taps_next;
        end
    end

    // Two-register pipeline handshake
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !sweep_busy && (!s1_valid_reg || s1_advance);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        info_next      = info_reg;
        out_valid_next = out_valid_reg;
        codeword_next  = codeword_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
            codeword_next  = encoded_bits;
            s1_valid_next  = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
            info_next     = info_word[CODE_LEN-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg     <= info_next;
        codeword_reg <= codeword_next;
    end

    // Encode datapath
    pacenc_placer #(
        .CODE_LEN (CODE_LEN)
    ) u_placer (
        .clk         (clk),
        .rst_n       (rst_n),
        .sweep_start (mask_write),
        .frozen_mask (frozen_mask_reg),
        .info_bits   (info_reg),
        .sweep_busy  (sweep_busy),
        .placed_bits (placed_bits)
    );

    pacenc_precoder #(
        .CODE_LEN (CODE_LEN),
        .CONV_MEM (CONV_MEM)
    ) u_precoder (
        .conv_taps (conv_taps_reg),
        .in_bits   (placed_bits),
        .out_bits  (precoded_bits)
    );

    pacenc_butterfly #(
        .CODE_LEN (CODE_LEN)
    ) u_butterfly (
        .in_bits  (precoded_bits),
        .out_bits (encoded_bits)
    );

    assign out_valid = out_valid_reg;
    assign codeword  = pacenc_pkg::WORD_W'(codeword_reg);

    // Assertions
    `PAC_ASSERT_NEXT(a_s1_holds_on_stall, clk, rst_n,
        s1_valid_reg && out_valid_reg && !out_ready,
        s1_valid_reg && $stable(info_reg))
    `PAC_ASSERT_NEXT(a_s1_moves_to_out, clk, rst_n,
        s1_valid_reg && (!out_valid_reg || out_ready),
        out_valid_reg)
    `PAC_ASSERT_NEXT(a_mask_write_sweeps, clk, rst_n,
        cfg_wr_en && (cfg_index == pacenc_pkg::CFG_FROZEN_MASK),
        sweep_busy && !in_ready)

endmodule
